@@ rtl/vn_pkg.sv @@
// ----------------------------------------------------------------------------
// vn_pkg
// shared widths and stage payload types for the vector normalize pipeline
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int unsigned CompW  = 32;
  localparam int unsigned SumW   = 2 * CompW;
  localparam int unsigned RootW  = SumW / 2;
  localparam int unsigned QuotW  = 31;
  localparam int unsigned Lanes  = 3;

  typedef struct packed {
    logic [Lanes-1:0][CompW-1:0] mag_c;
    logic [Lanes-1:0]            neg;
    logic                        three;
  } sq_tag_t;

  typedef struct packed {
    logic [RootW-1:0] mag;
    logic [Lanes-1:0] neg;
    logic             three;
  } dv_tag_t;

endpackage

@@ rtl/vector_normalize_top.sv @@
// ----------------------------------------------------------------------------
// vector_normalize_top
// length and unit direction of a 2d or 3d q16.16 vector
// ----------------------------------------------------------------------------
// One vector is accepted per cycle while the output side does not stall. The
// pipeline is made of three stages of absolute value, squaring and summing,
// 32 square-root stages (one root bit each) and 31 divider stages (one
// quotient bit each), plus the output register. A stall on the output
// freezes the whole pipeline.
// ----------------------------------------------------------------------------
module vector_normalize_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // comp_x, comp_y, comp_z
  input  logic [0:0]   in_tuser,   // three_dims
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // unit_x, unit_y, unit_z, magnitude
  output logic [0:0]   out_tuser   // zero_vector
);

  logic                                              en;
  logic [vn_pkg::Lanes-1:0][vn_pkg::CompW-1:0]       comp;
  logic                                              sq_vld, rt_vld, dv_vld;
  logic [vn_pkg::SumW-1:0]                           sum;
  vn_pkg::sq_tag_t                                   sq_tag, rt_tag;
  logic [vn_pkg::RootW-1:0]                          root;
  vn_pkg::dv_tag_t                                   dv_in_tag, dv_tag;
  logic [vn_pkg::Lanes-1:0][vn_pkg::QuotW-1:0]       quot;
  logic                                              out_vld_r;
  logic [127:0]                                      data_r;
  logic                                              zero_r;
  logic [vn_pkg::Lanes-1:0][vn_pkg::CompW-1:0]       unit;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign comp      = in_tdata;

  vn_square u_square (
    .clk, .rst_n, .en,
    .in_vld  (in_tvalid),
    .comp    (comp),
    .three   (in_tuser[0]),
    .out_vld (sq_vld),
    .sum     (sum),
    .tag     (sq_tag)
  );

  vn_isqrt #(.tag_t(vn_pkg::sq_tag_t)) u_isqrt (
    .clk, .rst_n, .en,
    .in_vld  (sq_vld),
    .val     (sum),
    .in_tag  (sq_tag),
    .out_vld (rt_vld),
    .root    (root),
    .out_tag (rt_tag)
  );

  assign dv_in_tag.mag   = root;
  assign dv_in_tag.neg   = rt_tag.neg;
  assign dv_in_tag.three = rt_tag.three;

  vn_divide u_divide (
    .clk, .rst_n, .en,
    .in_vld  (rt_vld),
    .num     (rt_tag.mag_c),
    .in_tag  (dv_in_tag),
    .out_vld (dv_vld),
    .quot    (quot),
    .out_tag (dv_tag)
  );

  always_comb begin
    for (int l = 0; l < vn_pkg::Lanes; l++) begin
      unit[l] = dv_tag.neg[l] ? (~{1'b0, quot[l]} + 1'b1) : {1'b0, quot[l]};
    end
    if (!dv_tag.three) begin
      unit[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_tag.mag == '0) begin
        data_r <= '0;
        zero_r <= 1'b1;
      end else begin
        data_r <= {dv_tag.mag, unit[2], unit[1], unit[0]};
        zero_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = data_r;
  assign out_tuser[0] = zero_r;

endmodule

@@ rtl/vn_square.sv @@
// ----------------------------------------------------------------------------
// vn_square
// absolute values, squares and sum of squares over three register stages
// ----------------------------------------------------------------------------
module vn_square (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            in_vld,
  input  logic [vn_pkg::Lanes-1:0][vn_pkg::CompW-1:0]     comp,
  input  logic                                            three,
  output logic                                            out_vld,
  output logic [vn_pkg::SumW-1:0]                         sum,
  output vn_pkg::sq_tag_t                                 tag
);

  logic [2:0]                                          vld_r;
  vn_pkg::sq_tag_t                                     t1_r, t2_r, t3_r;
  logic [vn_pkg::Lanes-1:0][vn_pkg::SumW-1:0]          prod_r;
  logic [vn_pkg::SumW-1:0]                             sum_r;
  vn_pkg::sq_tag_t                                     t1_nxt;

  always_comb begin
    for (int l = 0; l < vn_pkg::Lanes; l++) begin
      t1_nxt.neg[l]   = comp[l][vn_pkg::CompW-1];
      t1_nxt.mag_c[l] = comp[l][vn_pkg::CompW-1] ? (~comp[l] + 1'b1) : comp[l];
    end
    if (!three) begin
      t1_nxt.mag_c[2] = '0;
      t1_nxt.neg[2]   = 1'b0;
    end
    t1_nxt.three = three;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t1_nxt;
      for (int l = 0; l < vn_pkg::Lanes; l++) begin
        prod_r[l] <= vn_pkg::SumW'(t1_r.mag_c[l]) * vn_pkg::SumW'(t1_r.mag_c[l]);
      end
      t2_r  <= t1_r;
      sum_r <= prod_r[0] + prod_r[1] + prod_r[2];
      t3_r  <= t2_r;
    end
  end

  assign out_vld = vld_r[2];
  assign sum     = sum_r;
  assign tag     = t3_r;

endmodule

@@ rtl/vn_isqrt.sv @@
// ----------------------------------------------------------------------------
// vn_isqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module vn_isqrt #(
  parameter type tag_t = vn_pkg::sq_tag_t
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [vn_pkg::SumW-1:0]    val,
  input  tag_t                       in_tag,
  output logic                       out_vld,
  output logic [vn_pkg::RootW-1:0]   root,
  output tag_t                       out_tag
);

  localparam int unsigned N    = vn_pkg::RootW;
  localparam int unsigned RemW = vn_pkg::RootW + 2;

  logic [N-1:0]              vld_r;
  logic [vn_pkg::SumW-1:0]   val_r  [N];
  logic [RemW-1:0]           rem_r  [N];
  logic [N-1:0]              root_r [N];
  tag_t                      tag_r  [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [vn_pkg::SumW-1:0] s_val;
    logic [RemW-1:0]         s_rem, t_rem, trial;
    logic [N-1:0]            s_root;
    tag_t                    s_tag;
    if (k == 0) begin : g_first
      assign s_val  = val;
      assign s_rem  = '0;
      assign s_root = '0;
      assign s_tag  = in_tag;
    end else begin : g_next
      assign s_val  = val_r[k-1];
      assign s_rem  = rem_r[k-1];
      assign s_root = root_r[k-1];
      assign s_tag  = tag_r[k-1];
    end
    assign t_rem = {s_rem[RemW-3:0], s_val[vn_pkg::SumW-1 -: 2]};
    assign trial = {s_root, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k] <= {s_val[vn_pkg::SumW-3:0], 2'b00};
        tag_r[k] <= s_tag;
        if (t_rem >= trial) begin
          rem_r[k]  <= t_rem - trial;
          root_r[k] <= {s_root[N-2:0], 1'b1};
        end else begin
          rem_r[k]  <= t_rem;
          root_r[k] <= {s_root[N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign root    = root_r[N-1];
  assign out_tag = tag_r[N-1];

endmodule

@@ rtl/vn_divide.sv @@
// ----------------------------------------------------------------------------
// vn_divide
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vn_divide (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  logic                                           in_vld,
  input  logic [vn_pkg::Lanes-1:0][vn_pkg::CompW-1:0]    num,
  input  vn_pkg::dv_tag_t                                in_tag,
  output logic                                           out_vld,
  output logic [vn_pkg::Lanes-1:0][vn_pkg::QuotW-1:0]    quot,
  output vn_pkg::dv_tag_t                                out_tag
);

  localparam int unsigned N  = vn_pkg::QuotW;
  localparam int unsigned RW = vn_pkg::RootW;

  logic [N-1:0]                                vld_r;
  logic [vn_pkg::Lanes-1:0][RW-1:0]            rem_r [N];
  logic [vn_pkg::Lanes-1:0][N-1:0]             q_r   [N];
  vn_pkg::dv_tag_t                             tag_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [vn_pkg::Lanes-1:0][RW-1:0] s_rem;
    logic [vn_pkg::Lanes-1:0]         s_bit;
    logic [vn_pkg::Lanes-1:0][N-1:0]  s_q;
    vn_pkg::dv_tag_t                  s_tag;
    if (k == 0) begin : g_first
      for (genvar l = 0; l < vn_pkg::Lanes; l++) begin : g_lane
        assign s_rem[l] = {1'b0, num[l][vn_pkg::CompW-1:1]};
        assign s_bit[l] = num[l][0];
      end
      assign s_q   = '0;
      assign s_tag = in_tag;
    end else begin : g_next
      assign s_rem = rem_r[k-1];
      assign s_bit = '0;
      assign s_q   = q_r[k-1];
      assign s_tag = tag_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= s_tag;
        for (int l = 0; l < vn_pkg::Lanes; l++) begin
          logic [RW:0] t;
          t = {s_rem[l], s_bit[l]};
          if (t >= {1'b0, s_tag.mag}) begin
            rem_r[k][l] <= RW'(t - {1'b0, s_tag.mag});
            q_r[k][l]   <= {s_q[l][N-2:0], 1'b1};
          end else begin
            rem_r[k][l] <= t[RW-1:0];
            q_r[k][l]   <= {s_q[l][N-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign quot    = q_r[N-1];
  assign out_tag = tag_r[N-1];

endmodule

@@ sim/vector_normalize_top_test.sv @@
// ----------------------------------------------------------------------------
// vector_normalize_top_test
// self-checking bench for the 2d/3d vector normalize pipeline
// ----------------------------------------------------------------------------
// Vectors mostly stream in with random gaps. A predictor computes the exact
// sum of squares, its integer square root and the truncated Q2.30 quotients.
// Each output transfer is compared with the oldest prediction. A long output
// stall fills the pipeline, one phase has no gaps, and each phase drains it.
// ----------------------------------------------------------------------------
module vector_normalize_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] ux, uy, uz, mag;
    logic        zero;
  } unit_vec_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;

  unit_vec_t expected_q[$];
  int        errors = 0;
  int        n_vec = 0;
  int        n_res = 0;
  int        n_zero = 0;
  int        idle_cycles = 0;
  bit        hold_off = 1'b0;
  bit        gaps_on = 1'b1;

  vector_normalize_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] abs_c(input logic [31:0] c);
    return c[31] ? -c : c;
  endfunction

  function automatic logic [31:0] unit_comp(input logic [31:0] c, input logic [63:0] m);
    logic [63:0] q;
    q = ({32'd0, abs_c(c)} << 30) / m;
    if (c[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic unit_vec_t normalize(input logic [31:0] x, y, z, input logic three);
    unit_vec_t u;
    logic [63:0] ax, ay, az, s, m;
    ax = 64'(abs_c(x));
    ay = 64'(abs_c(y));
    az = three ? 64'(abs_c(z)) : 64'd0;
    s = ax * ax + ay * ay + az * az;
    m = int_sqrt(s);
    u = '{default: '0};
    if (m == 0) begin
      u.zero = 1'b1;
    end else begin
      u.ux = unit_comp(x, m);
      u.uy = unit_comp(y, m);
      u.uz = three ? unit_comp(z, m) : 32'd0;
      u.mag = m[31:0];
    end
    return u;
  endfunction

  function automatic int gap_len();
    if (!gaps_on) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_vector(input logic [31:0] x, y, z, input logic three);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    in_tuser  <= three;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(normalize(x, y, z, three));
    n_vec++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // output checker
  always @(posedge clk) begin
    unit_vec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_res++;
      if (out_tuser[0]) n_zero++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transfer exp none got %h", $time, out_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[31:0] !== e.ux) begin
          $display("%0t unit_x exp %h got %h", $time, e.ux, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== e.uy) begin
          $display("%0t unit_y exp %h got %h", $time, e.uy, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[95:64] !== e.uz) begin
          $display("%0t unit_z exp %h got %h", $time, e.uz, out_tdata[95:64]);
          errors++;
        end
        if (out_tdata[127:96] !== e.mag) begin
          $display("%0t magnitude exp %h got %h", $time, e.mag, out_tdata[127:96]);
          errors++;
        end
        if (out_tuser[0] !== e.zero) begin
          $display("%0t zero_vector exp %b got %b", $time, e.zero, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (!gaps_on) out_tready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_tready <= ~out_tready;
    else out_tready <= 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15) - 8;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_vector(0, 0, 0, 1'b0);
    send_vector(0, 0, 0, 1'b1);
    send_vector(0, 0, 32'h1234_5678, 1'b0);
    send_vector(32'h0001_0000, 0, 0, 1'b0);
    send_vector(0, 32'hffff_0000, 0, 1'b1);
    send_vector(0, 0, 32'h0003_0000, 1'b1);
    send_vector(32'h8000_0000, 0, 0, 1'b0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_vector(32'h7fff_ffff, 32'h8000_0000, 32'h5555_aaaa, 1'b0);
    send_vector(1, 0, 0, 1'b0);
    send_vector(32'hffff_ffff, 1, 32'hffff_ffff, 1'b1);
    send_vector(1, 1, 1, 1'b1);
    send_vector(32'h0003_0000, 32'h0004_0000, 0, 1'b0);
    send_vector(32'hfffd_0000, 32'h0004_0000, 32'hfff4_0000, 1'b1);
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_vector(32'haaaa_5555, 32'h5555_aaaa, 32'hffff_ffff, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_vector(rand_comp(), rand_comp(), rand_comp(),
                               1'($urandom_range(0, 1)));
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(120);
    join
    wait_drained();
  endtask

  task automatic test_full_rate();
    gaps_on = 1'b0;
    test_random(150);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400);
    wait_drained();
    test_back_pressure();
    test_full_rate();
    test_random(380);
    wait_drained();
    repeat (100) @(posedge clk);
    $display("%0d vectors checked, %0d zero-length, with stalls, gaps and full rate",
             n_res, n_zero);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
